// ----- design/rpmc_pkg.sv -----
`default_nettype none

package rpmc_pkg;

    localparam int unsigned DebounceW = 8;
    localparam int unsigned CurrentW  = 16;
    localparam int unsigned CfgDataW  = 16;
    localparam int unsigned CfgIndexW = 1;
    localparam int unsigned PatMsW    = 12;

    // Configuration register indexes.
    localparam logic [CfgIndexW-1:0] CFG_DEBOUNCE      = 1'b0;
    localparam logic [CfgIndexW-1:0] CFG_FAULT_CURRENT = 1'b1;

    localparam logic [DebounceW-1:0] DEBOUNCE_RESET = 8'd50;
    localparam logic [CurrentW-1:0]  FAULT_RESET    = 16'd100;
    localparam logic [DebounceW-1:0] STABLE_MAX     = 8'd255;

    // Blink pattern timing in 1 ms ticks.
    localparam logic [PatMsW-1:0] THREE_PERIOD = 12'd1900;
    localparam logic [PatMsW-1:0] ALT_PERIOD   = 12'd3000;
    localparam logic [PatMsW-1:0] ALT_HALF     = 12'd1500;
    localparam logic [PatMsW-1:0] BLINK_MS     = 12'd150;
    localparam logic [PatMsW-1:0] TWO_END      = 12'd600;

    typedef enum logic [3:0] {
        OP_TICK          = 4'd0,
        OP_TURN_ON       = 4'd1,
        OP_TURN_OFF      = 4'd2,
        OP_ALERT         = 4'd3,
        OP_ALERT_OFF     = 4'd4,
        OP_LINK_UP       = 4'd5,
        OP_LINK_DOWN     = 4'd6,
        OP_BROKER_UP     = 4'd7,
        OP_BROKER_LOST   = 4'd8,
        OP_CURRENT_CHECK = 4'd9
    } op_t;

    typedef enum logic [1:0] {
        MODE_LINK   = 2'd0,
        MODE_BROKER = 2'd1,
        MODE_ONLINE = 2'd2,
        MODE_ALERT  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        PAT_SOLID = 2'd0,
        PAT_THREE = 2'd1,
        PAT_TWO   = 2'd2,
        PAT_ALT   = 2'd3
    } pattern_t;

    typedef struct packed {
        mode_t                mode;
        logic                 fault;
        logic                 relay;
        logic                 led;
        pattern_t             pattern;
        logic [PatMsW-1:0]    pattern_ms;
        logic                 solid_level;
        logic                 link_down;
        logic                 first_connect_done;
        logic                 button_prev;
        logic [DebounceW-1:0] button_stable_ms;
        logic                 button_handled;
    } state_t;

    localparam state_t STATE_RESET = '{
        mode:               MODE_LINK,
        fault:              1'b0,
        relay:              1'b0,
        led:                1'b0,
        pattern:            PAT_THREE,
        pattern_ms:         '0,
        solid_level:        1'b0,
        link_down:          1'b1,
        first_connect_done: 1'b0,
        button_prev:        1'b0,
        button_stable_ms:   '0,
        button_handled:     1'b0
    };

    typedef struct packed {
        logic [3:0]          operation;
        logic                button_level;
        logic [CurrentW-1:0] current_ma;
        logic                current_valid;
    } item_t;

    typedef struct packed {
        logic  relay_drive;
        logic  led_on;
        mode_t mode;
        logic  fault_mode;
        logic  ev_switch_on;
        logic  ev_switch_off;
        logic  ev_alert;
        logic  ev_alert_off;
        logic  ev_relay_fault;
        logic  restart_request;
        logic  acknowledged;
        logic  status_request;
    } result_t;

    // Two short blinks: on for the first and third 150 ms slot.
    function automatic logic two_blink_on(input logic [PatMsW-1:0] t);
        return (t < BLINK_MS) || ((t >= 2 * BLINK_MS) && (t < 3 * BLINK_MS));
    endfunction

    // Three short blinks: on for the first, third and fifth 150 ms slot.
    function automatic logic three_blink_on(input logic [PatMsW-1:0] t);
        return two_blink_on(t) || ((t >= 4 * BLINK_MS) && (t < 5 * BLINK_MS));
    endfunction

endpackage

`default_nettype wire

// ----- design/relay_plug_mode_controller_core.sv -----
`default_nettype none

// Mode controller for a switched outlet. Each input item is a 1 ms tick with the raw
// button level, a remote command, a link or broker event, or a load current check, and
// every item produces exactly one result item carrying the relay and LED levels, the
// connection mode and fault latch after that item, plus event flags for that item. Items
// move through two registers: an accepted item is held in an input register, and once
// the result register is free a single pass of shallow logic updates the controller
// state and loads the result register, where the result is presented until it is
// taken. One item is accepted in every cycle for as long as results are taken; the
// rate is set by that single state update, which every item must see from its
// predecessor. The result register lets a new item enter while a finished result
// still waits. The two configuration registers (debounce ticks at index 0, fault
// current threshold in mA at index 1) are written through the plain write port and
// should only change while the block is idle. All state is flip-flops and is ready
// right after reset.
module relay_plug_mode_controller_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [rpmc_pkg::CfgIndexW-1:0]      cfg_index,
    input  logic [rpmc_pkg::CfgDataW-1:0]       cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [3:0]                          operation,
    input  logic                                button_level,
    input  logic [rpmc_pkg::CurrentW-1:0]       current_ma,
    input  logic                                current_valid,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                relay_drive,
    output logic                                led_on,
    output logic [1:0]                          mode,
    output logic                                fault_mode,
    output logic                                ev_switch_on,
    output logic                                ev_switch_off,
    output logic                                ev_alert,
    output logic                                ev_alert_off,
    output logic                                ev_relay_fault,
    output logic                                restart_request,
    output logic                                acknowledged,
    output logic                                status_request
);
    import rpmc_pkg::*;

    logic [DebounceW-1:0] debounce_reg;
    logic [CurrentW-1:0]  fault_current_reg;

    item_t   item_reg;
    logic    item_valid_reg;
    state_t  state_reg;
    state_t  state_next;
    result_t result_reg;
    result_t result_next;
    logic    out_valid_reg;

    logic    out_free;
    logic    advance;

    // The result register is free when empty or being drained this cycle.
    assign out_free = !out_valid_reg || out_ready;
    assign advance  = item_valid_reg && out_free;
    assign in_ready = !item_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg      <= DEBOUNCE_RESET;
            fault_current_reg <= FAULT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DEBOUNCE:      debounce_reg      <= cfg_data[DebounceW-1:0];
                CFG_FAULT_CURRENT: fault_current_reg <= cfg_data[CurrentW-1:0];
                default:           debounce_reg      <= debounce_reg;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            item_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= '{operation:     operation,
                          button_level:  button_level,
                          current_ma:    current_ma,
                          current_valid: current_valid};
        end
    end

    rpmc_step u_step (
        .cur              (state_reg),
        .item             (item_reg),
        .debounce_ms      (debounce_reg),
        .fault_current_ma (fault_current_reg),
        .nxt              (state_next),
        .res              (result_next)
    );

    // Controller state advances exactly once per item, as it enters the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= STATE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                state_reg <= state_next;
            end
            if (out_free)
            begin
                out_valid_reg <= item_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign relay_drive     = result_reg.relay_drive;
    assign led_on          = result_reg.led_on;
    assign mode            = result_reg.mode;
    assign fault_mode      = result_reg.fault_mode;
    assign ev_switch_on    = result_reg.ev_switch_on;
    assign ev_switch_off   = result_reg.ev_switch_off;
    assign ev_alert        = result_reg.ev_alert;
    assign ev_alert_off    = result_reg.ev_alert_off;
    assign ev_relay_fault  = result_reg.ev_relay_fault;
    assign restart_request = result_reg.restart_request;
    assign acknowledged    = result_reg.acknowledged;
    assign status_request  = result_reg.status_request;

    // A latched fault is only ever entered from, and held in, the online mode.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fault_mode |-> mode == MODE_ONLINE)
        else $error("fault latched outside online mode");

    // A relay fault event means the relay is off and the latch is set.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ev_relay_fault |-> fault_mode && !relay_drive)
        else $error("relay fault event without latched fault");

    // The relay cannot switch both ways on one item.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $onehot0({ev_switch_on, ev_switch_off}))
        else $error("relay on and off events together");

    // Input back-pressure only when both stages hold items and the output stalls.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> item_valid_reg && out_valid_reg && !out_ready)
        else $error("input stalled without a full pipeline");

endmodule

`default_nettype wire

// ----- design/rpmc_step.sv -----
`default_nettype none

module rpmc_step (
    input  rpmc_pkg::state_t                     cur,
    input  rpmc_pkg::item_t                      item,
    input  logic [rpmc_pkg::DebounceW-1:0]       debounce_ms,
    input  logic [rpmc_pkg::CurrentW-1:0]        fault_current_ma,
    output rpmc_pkg::state_t                     nxt,
    output rpmc_pkg::result_t                    res
);
    import rpmc_pkg::*;

    // Selecting a pattern restarts its timer; a solid pattern drives the LED at once.
    function automatic state_t with_pattern(input state_t s, input pattern_t p,
                                            input logic solid);
        state_t r;
        r = s;
        r.pattern     = p;
        r.pattern_ms  = '0;
        r.solid_level = solid;
        if (p == PAT_SOLID)
        begin
            r.led = solid;
        end
        return r;
    endfunction

    state_t            s;
    logic [PatMsW-1:0] t;
    logic              cmd_ok;

    assign cmd_ok = (item.operation >= OP_TURN_ON) && (item.operation <= OP_ALERT_OFF)
                    && !cur.fault;
    assign t = cur.pattern_ms;

    always_comb
    begin
        s   = cur;
        res = '0;
        if (cmd_ok)
        begin
            case (op_t'(item.operation))
                OP_TURN_ON:
                begin
                    s.relay = 1'b1;
                    res.ev_switch_on   = 1'b1;
                    res.acknowledged   = 1'b1;
                    res.status_request = 1'b1;
                    s = with_pattern(s, PAT_TWO, 1'b1);
                end
                OP_TURN_OFF:
                begin
                    s.relay = 1'b0;
                    res.ev_switch_off  = 1'b1;
                    res.acknowledged   = 1'b1;
                    res.status_request = 1'b1;
                    if (cur.mode == MODE_ALERT)
                    begin
                        // Switching off during an alert latches the fault.
                        s.mode  = MODE_ONLINE;
                        s.fault = 1'b1;
                        res.ev_alert_off = 1'b1;
                        s = with_pattern(s, PAT_THREE, 1'b0);
                    end
                    else
                    begin
                        s = with_pattern(s, PAT_TWO, 1'b1);
                    end
                end
                OP_ALERT:
                begin
                    if (cur.mode == MODE_ONLINE)
                    begin
                        s.mode = MODE_ALERT;
                        res.ev_alert       = 1'b1;
                        res.acknowledged   = 1'b1;
                        res.status_request = 1'b1;
                        s = with_pattern(s, PAT_ALT, 1'b0);
                    end
                end
                default:
                begin
                    if (cur.mode == MODE_ALERT)
                    begin
                        s.mode = MODE_ONLINE;
                        res.ev_alert_off   = 1'b1;
                        res.acknowledged   = 1'b1;
                        res.status_request = 1'b1;
                        s = with_pattern(s, PAT_SOLID, 1'b1);
                    end
                end
            endcase
        end
        else
        begin
            case (op_t'(item.operation))
                OP_LINK_UP:
                begin
                    if (cur.link_down)
                    begin
                        s.link_down = 1'b0;
                        s.mode      = MODE_BROKER;
                        s.fault     = 1'b0;
                        s = with_pattern(s, PAT_SOLID, 1'b1);
                    end
                end
                OP_LINK_DOWN:
                begin
                    if (!cur.link_down)
                    begin
                        s.link_down = 1'b1;
                        if (cur.fault || (cur.mode != MODE_LINK && cur.mode != MODE_BROKER))
                        begin
                            s = with_pattern(s, PAT_THREE, 1'b0);
                        end
                    end
                end
                OP_BROKER_UP:
                begin
                    if (!cur.link_down)
                    begin
                        res.status_request = 1'b1;
                        if (!cur.first_connect_done)
                        begin
                            s.first_connect_done = 1'b1;
                            s = with_pattern(s, PAT_TWO, 1'b1);
                        end
                        if (cur.mode == MODE_BROKER && !cur.fault)
                        begin
                            s.mode = MODE_ONLINE;
                            s = with_pattern(s, PAT_SOLID, 1'b1);
                        end
                    end
                end
                OP_BROKER_LOST:
                begin
                    if (!cur.link_down && cur.mode == MODE_ONLINE && !cur.fault)
                    begin
                        s.mode = MODE_BROKER;
                    end
                end
                OP_CURRENT_CHECK:
                begin
                    if (!cur.link_down && cur.mode == MODE_ONLINE && !cur.fault
                        && item.current_valid && !cur.relay
                        && (item.current_ma > fault_current_ma))
                    begin
                        s.fault = 1'b1;
                        res.ev_relay_fault = 1'b1;
                        s = with_pattern(s, PAT_THREE, 1'b0);
                    end
                end
                OP_TICK:
                begin
                    // Debounce: count ticks at a steady level, saturating.
                    if (item.button_level != cur.button_prev)
                    begin
                        s.button_stable_ms = '0;
                    end
                    else if (cur.button_stable_ms < STABLE_MAX)
                    begin
                        s.button_stable_ms = cur.button_stable_ms + 8'd1;
                    end
                    s.button_prev = item.button_level;
                    if (item.button_level && (s.button_stable_ms > debounce_ms))
                    begin
                        if (!cur.button_handled)
                        begin
                            s.button_handled = 1'b1;
                            if (cur.fault)
                            begin
                                res.restart_request = 1'b1;
                            end
                            else if (cur.mode != MODE_LINK)
                            begin
                                s.relay = !cur.relay;
                                res.ev_switch_on  = !cur.relay;
                                res.ev_switch_off = cur.relay;
                            end
                        end
                    end
                    else if (!item.button_level)
                    begin
                        s.button_handled = 1'b0;
                    end
                    // The timer never reaches the period of the active pattern.
                    case (cur.pattern)
                        PAT_THREE:
                        begin
                            s.led = three_blink_on(t);
                            s.pattern_ms = (t >= THREE_PERIOD - 12'd1) ? '0 : t + 12'd1;
                        end
                        PAT_TWO:
                        begin
                            if (t < TWO_END)
                            begin
                                s.led        = two_blink_on(t);
                                s.pattern_ms = t + 12'd1;
                            end
                            else
                            begin
                                s.led        = cur.solid_level;
                                s.pattern    = PAT_SOLID;
                                s.pattern_ms = '0;
                            end
                        end
                        PAT_ALT:
                        begin
                            s.led = (t < ALT_HALF);
                            s.pattern_ms = (t >= ALT_PERIOD - 12'd1) ? '0 : t + 12'd1;
                        end
                        default:
                        begin
                            s.led = cur.led;
                        end
                    endcase
                end
                default:
                begin
                    s = cur;
                end
            endcase
        end
        res.relay_drive = s.relay;
        res.led_on      = s.led;
        res.mode        = s.mode;
        res.fault_mode  = s.fault;
    end

    assign nxt = s;

endmodule

`default_nettype wire

// ----- tb/plug_mode_checker.sv -----
`timescale 1ns / 100ps

// Watches both channels and the write port of the outlet mode controller.
// It keeps its own copy of the controller state, works out the result for
// every accepted item, and compares each returned result in order.
module plug_mode_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [rpmc_pkg::CfgIndexW-1:0] cfg_index,
    input  logic [rpmc_pkg::CfgDataW-1:0]  cfg_data,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  logic [3:0]                     operation,
    input  logic                           button_level,
    input  logic [rpmc_pkg::CurrentW-1:0]  current_ma,
    input  logic                           current_valid,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic                           relay_drive,
    input  logic                           led_on,
    input  logic [1:0]                     mode,
    input  logic                           fault_mode,
    input  logic                           ev_switch_on,
    input  logic                           ev_switch_off,
    input  logic                           ev_alert,
    input  logic                           ev_alert_off,
    input  logic                           ev_relay_fault,
    input  logic                           restart_request,
    input  logic                           acknowledged,
    input  logic                           status_request,
    output int                             mismatch_total,
    output int                             results_pending
);
    import rpmc_pkg::*;

    logic [DebounceW-1:0] debounce_lim;
    logic [CurrentW-1:0]  fault_limit;

    mode_t                cur_mode;
    logic                 fault_latch;
    logic                 relay_lvl;
    logic                 led_lvl;
    pattern_t             blink_pat;
    logic [PatMsW-1:0]    pat_ms;
    logic                 solid_lvl;
    logic                 link_is_down;
    logic                 connected_once;
    logic                 btn_last;
    logic [DebounceW-1:0] btn_stable;
    logic                 btn_done;

    result_t              expected_results[$];

    task automatic clear_controller();
        debounce_lim   = DEBOUNCE_RESET;
        fault_limit    = FAULT_RESET;
        cur_mode       = MODE_LINK;
        fault_latch    = 1'b0;
        relay_lvl      = 1'b0;
        led_lvl        = 1'b0;
        blink_pat      = PAT_THREE;
        pat_ms         = '0;
        solid_lvl      = 1'b0;
        link_is_down   = 1'b1;
        connected_once = 1'b0;
        btn_last       = 1'b0;
        btn_stable     = '0;
        btn_done       = 1'b0;
    endtask

    // A new pattern restarts its timer; only a solid one shows at once.
    task automatic start_pattern(input pattern_t pat, input logic lvl);
        blink_pat = pat;
        pat_ms    = '0;
        solid_lvl = lvl;
        if (pat == PAT_SOLID)
            led_lvl = lvl;
    endtask

    // One millisecond of the blink pattern: show the level at the current
    // time, then move the timer on.
    task automatic advance_blink();
        int t;
        t = int'(pat_ms);
        case (blink_pat)
            PAT_THREE:
            begin
                t = t % int'(THREE_PERIOD);
                led_lvl = (t < 5 * int'(BLINK_MS)) && ((t / int'(BLINK_MS)) % 2 == 0);
                pat_ms = (t + 1 >= int'(THREE_PERIOD)) ? '0 : PatMsW'(t + 1);
            end
            PAT_TWO:
            begin
                if (t < int'(TWO_END))
                begin
                    led_lvl = ((t / int'(BLINK_MS)) % 2 == 0);
                    pat_ms = PatMsW'(t + 1);
                end
                else
                begin
                    led_lvl = solid_lvl;
                    blink_pat = PAT_SOLID;
                    pat_ms = '0;
                end
            end
            PAT_ALT:
            begin
                t = t % int'(ALT_PERIOD);
                led_lvl = (t < int'(ALT_HALF));
                pat_ms = (t + 1 >= int'(ALT_PERIOD)) ? '0 : PatMsW'(t + 1);
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic advance_controller(input item_t it, output result_t r);
        r = '0;
        case (it.operation)
            OP_TURN_ON:
            begin
                if (!fault_latch)
                begin
                    relay_lvl = 1'b1;
                    r.ev_switch_on = 1'b1;
                    r.acknowledged = 1'b1;
                    r.status_request = 1'b1;
                    start_pattern(PAT_TWO, 1'b1);
                end
            end
            OP_TURN_OFF:
            begin
                if (!fault_latch)
                begin
                    relay_lvl = 1'b0;
                    r.ev_switch_off = 1'b1;
                    r.acknowledged = 1'b1;
                    r.status_request = 1'b1;
                    // Switching off during an alert counts as a fault.
                    if (cur_mode == MODE_ALERT)
                    begin
                        cur_mode = MODE_ONLINE;
                        fault_latch = 1'b1;
                        r.ev_alert_off = 1'b1;
                        start_pattern(PAT_THREE, 1'b0);
                    end
                    else
                        start_pattern(PAT_TWO, 1'b1);
                end
            end
            OP_ALERT:
            begin
                if (!fault_latch && cur_mode == MODE_ONLINE)
                begin
                    cur_mode = MODE_ALERT;
                    r.ev_alert = 1'b1;
                    r.acknowledged = 1'b1;
                    r.status_request = 1'b1;
                    start_pattern(PAT_ALT, 1'b0);
                end
            end
            OP_ALERT_OFF:
            begin
                if (!fault_latch && cur_mode == MODE_ALERT)
                begin
                    cur_mode = MODE_ONLINE;
                    r.ev_alert_off = 1'b1;
                    r.acknowledged = 1'b1;
                    r.status_request = 1'b1;
                    start_pattern(PAT_SOLID, 1'b1);
                end
            end
            OP_LINK_UP:
            begin
                if (link_is_down)
                begin
                    link_is_down = 1'b0;
                    cur_mode = MODE_BROKER;
                    fault_latch = 1'b0;
                    start_pattern(PAT_SOLID, 1'b1);
                end
            end
            OP_LINK_DOWN:
            begin
                if (!link_is_down)
                begin
                    link_is_down = 1'b1;
                    if (fault_latch || (cur_mode != MODE_LINK && cur_mode != MODE_BROKER))
                        start_pattern(PAT_THREE, 1'b0);
                end
            end
            OP_BROKER_UP:
            begin
                if (!link_is_down)
                begin
                    r.status_request = 1'b1;
                    if (!connected_once)
                    begin
                        connected_once = 1'b1;
                        start_pattern(PAT_TWO, 1'b1);
                    end
                    if (cur_mode == MODE_BROKER && !fault_latch)
                    begin
                        cur_mode = MODE_ONLINE;
                        start_pattern(PAT_SOLID, 1'b1);
                    end
                end
            end
            OP_BROKER_LOST:
            begin
                if (!link_is_down && cur_mode == MODE_ONLINE && !fault_latch)
                    cur_mode = MODE_BROKER;
            end
            OP_CURRENT_CHECK:
            begin
                if (!link_is_down && cur_mode == MODE_ONLINE && !fault_latch &&
                    it.current_valid && !relay_lvl && it.current_ma > fault_limit)
                begin
                    fault_latch = 1'b1;
                    r.ev_relay_fault = 1'b1;
                    start_pattern(PAT_THREE, 1'b0);
                end
            end
            OP_TICK:
            begin
                if (it.button_level != btn_last)
                    btn_stable = '0;
                else if (btn_stable < STABLE_MAX)
                    btn_stable = btn_stable + 1'b1;
                btn_last = it.button_level;
                if (it.button_level && btn_stable > debounce_lim)
                begin
                    if (!btn_done)
                    begin
                        btn_done = 1'b1;
                        if (fault_latch)
                            r.restart_request = 1'b1;
                        else if (cur_mode != MODE_LINK)
                        begin
                            relay_lvl = !relay_lvl;
                            if (relay_lvl)
                                r.ev_switch_on = 1'b1;
                            else
                                r.ev_switch_off = 1'b1;
                        end
                    end
                end
                else if (!it.button_level)
                    btn_done = 1'b0;
                advance_blink();
            end
            default:
            begin
            end
        endcase
        r.relay_drive = relay_lvl;
        r.led_on      = led_lvl;
        r.mode        = cur_mode;
        r.fault_mode  = fault_latch;
    endtask

    task automatic compare_field(input string fname, input int want, input int got);
        if (want != got)
        begin
            mismatch_total++;
            if (mismatch_total <= 10)
                $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, fname, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        item_t   it;
        result_t want;
        if (!rst_n)
        begin
            clear_controller();
            expected_results.delete();
            mismatch_total = 0;
            results_pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_DEBOUNCE:      debounce_lim = cfg_data[DebounceW-1:0];
                    CFG_FAULT_CURRENT: fault_limit = cfg_data[CurrentW-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (in_valid && in_ready)
            begin
                it.operation     = operation;
                it.button_level  = button_level;
                it.current_ma    = current_ma;
                it.current_valid = current_valid;
                advance_controller(it, want);
                expected_results.push_back(want);
            end
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatch_total++;
                    if (mismatch_total <= 10)
                        $display("%0t: result with no item waiting", $realtime);
                end
                else
                begin
                    want = expected_results.pop_front();
                    compare_field("relay_drive", want.relay_drive, relay_drive);
                    compare_field("led_on", want.led_on, led_on);
                    compare_field("mode", want.mode, mode);
                    compare_field("fault_mode", want.fault_mode, fault_mode);
                    compare_field("ev_switch_on", want.ev_switch_on, ev_switch_on);
                    compare_field("ev_switch_off", want.ev_switch_off, ev_switch_off);
                    compare_field("ev_alert", want.ev_alert, ev_alert);
                    compare_field("ev_alert_off", want.ev_alert_off, ev_alert_off);
                    compare_field("ev_relay_fault", want.ev_relay_fault, ev_relay_fault);
                    compare_field("restart_request", want.restart_request, restart_request);
                    compare_field("acknowledged", want.acknowledged, acknowledged);
                    compare_field("status_request", want.status_request, status_request);
                end
            end
            results_pending <= expected_results.size();
        end
    end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps

// Stimulus and verdict for the outlet mode controller. The checker beside the
// block predicts and compares every result; this module only drives items,
// writes the two configuration registers between phases and decides the end.
module tb_top;
    import rpmc_pkg::*;

    // Operation codes from here up are unused and must leave the state alone.
    localparam logic [3:0] OP_FIRST_UNUSED = 4'd10;
    localparam logic [3:0] OP_LAST_UNUSED  = 4'd15;
    localparam int         DrainLimit      = 2000;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CfgIndexW-1:0] cfg_index = '0;
    logic [CfgDataW-1:0]  cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [3:0]           operation = '0;
    logic                 button_level = 1'b0;
    logic [CurrentW-1:0]  current_ma = '0;
    logic                 current_valid = 1'b0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic                 relay_drive;
    logic                 led_on;
    logic [1:0]           mode;
    logic                 fault_mode;
    logic                 ev_switch_on;
    logic                 ev_switch_off;
    logic                 ev_alert;
    logic                 ev_alert_off;
    logic                 ev_relay_fault;
    logic                 restart_request;
    logic                 acknowledged;
    logic                 status_request;

    int                   mismatches;
    int                   results_pending;

    // Percent chance per cycle that the sender holds back or the receiver
    // refuses a result. Changed between phases.
    int                   send_idle_pct = 0;
    int                   recv_idle_pct = 0;
    int                   items_sent = 0;

    // The stimulus keeps track of what it wrote, so that button holds and
    // load currents can be placed right around the thresholds.
    int                   debounce_now = DEBOUNCE_RESET;
    logic [CurrentW-1:0]  fault_now = FAULT_RESET;

    always #10 clk = ~clk;

    relay_plug_mode_controller_core u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .operation       (operation),
        .button_level    (button_level),
        .current_ma      (current_ma),
        .current_valid   (current_valid),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .relay_drive     (relay_drive),
        .led_on          (led_on),
        .mode            (mode),
        .fault_mode      (fault_mode),
        .ev_switch_on    (ev_switch_on),
        .ev_switch_off   (ev_switch_off),
        .ev_alert        (ev_alert),
        .ev_alert_off    (ev_alert_off),
        .ev_relay_fault  (ev_relay_fault),
        .restart_request (restart_request),
        .acknowledged    (acknowledged),
        .status_request  (status_request)
    );

    plug_mode_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .operation       (operation),
        .button_level    (button_level),
        .current_ma      (current_ma),
        .current_valid   (current_valid),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .relay_drive     (relay_drive),
        .led_on          (led_on),
        .mode            (mode),
        .fault_mode      (fault_mode),
        .ev_switch_on    (ev_switch_on),
        .ev_switch_off   (ev_switch_off),
        .ev_alert        (ev_alert),
        .ev_alert_off    (ev_alert_off),
        .ev_relay_fault  (ev_relay_fault),
        .restart_request (restart_request),
        .acknowledged    (acknowledged),
        .status_request  (status_request),
        .mismatch_total  (mismatches),
        .results_pending (results_pending)
    );

    // The receiver makes a fresh decision every cycle. Since every item gives
    // exactly one result, stalls here back up into in_ready quickly.
    always @(posedge clk)
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    // Present one item and hold it until the block takes it. The idle loop
    // lowers valid only between items, so valid never drops while an item
    // is waiting, and each cycle sees a single assignment to it.
    task automatic send_item(input logic [3:0] op, input logic btn,
                             input logic [CurrentW-1:0] cur, input logic cur_ok);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        operation     <= op;
        button_level  <= btn;
        current_ma    <= cur;
        current_valid <= cur_ok;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
    endtask

    // Commands and events ignore the button and current fields, so those are
    // filled with noise to show that they really are ignored.
    task automatic send_plain(input logic [3:0] op);
        send_item(op, 1'($urandom), 16'($urandom), 1'($urandom));
    endtask

    // Registers are only written once every result has come back. The pending
    // count is registered behind the handshake, hence the first wait.
    task automatic drain_results();
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_pending != 0 && waited < DrainLimit)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (4) @(posedge clk);
    endtask

    // The write enable drops for a cycle after each write, so back-to-back
    // writes never assign it twice at one edge.
    task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_thresholds(input int deb, input logic [CurrentW-1:0] limit);
        write_reg(CFG_DEBOUNCE, CfgDataW'(deb));
        write_reg(CFG_FAULT_CURRENT, limit);
        debounce_now = deb;
        fault_now = limit;
    endtask

    // A press held for debounce+1 ticks falls one short of registering; one
    // or two ticks more and it counts. The release that follows re-arms it.
    task automatic press_button();
        int hold;
        hold = debounce_now + $urandom_range(1, 3);
        repeat (hold) send_item(OP_TICK, 1'b1, 16'($urandom), 1'($urandom));
        repeat ($urandom_range(1, 4)) send_item(OP_TICK, 1'b0, 16'($urandom), 1'($urandom));
    endtask

    task automatic check_current();
        logic [CurrentW-1:0] cur;
        case ($urandom_range(0, 4))
            0:       cur = fault_now;
            1:       cur = (fault_now == '1) ? fault_now : fault_now + 1'b1;
            2:       cur = 16'($urandom);
            3:       cur = '1;
            default: cur = '0;
        endcase
        // The check only bites with the relay off, so switch it off first now
        // and then.
        if ($urandom_range(0, 2) == 0)
            send_plain(OP_TURN_OFF);
        send_item(OP_CURRENT_CHECK, 1'($urandom), cur, $urandom_range(0, 9) != 0);
    endtask

    // Link and broker events lean towards coming up, so that most of the run
    // is spent online where commands, checks and the button all act.
    task automatic network_event();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            send_plain(OP_LINK_UP);
        else if (pick < 70)
            send_plain(OP_BROKER_UP);
        else if (pick < 85)
            send_plain(OP_BROKER_LOST);
        else
            send_plain(OP_LINK_DOWN);
    endtask

    task automatic random_scenario();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 25)
            press_button();
        else if (pick < 42)
        begin
            // Loose ticks with a bouncing button level.
            repeat ($urandom_range(1, 12))
                send_item(OP_TICK, 1'($urandom), 16'($urandom), 1'($urandom));
        end
        else if (pick < 62)
            send_plain(4'($urandom_range(OP_TURN_ON, OP_ALERT_OFF)));
        else if (pick < 82)
            network_event();
        else if (pick < 96)
            check_current();
        else
            send_plain(4'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED)));
    endtask

    task automatic run_phase(input int count, input int send_pct, input int recv_pct);
        int target;
        target = items_sent + count;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        while (items_sent < target)
            random_scenario();
    endtask

    // Hard limit in case the block stops handing over items or results.
    initial
    begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed walk through the modes with the thresholds at their reset
        // values: ignored events while disconnected, first broker connect,
        // alerts, the current fault and its clearing by a link cycle, and
        // switching off during an alert.
        send_idle_pct = 31;
        recv_idle_pct = 54;
        send_item(OP_TICK, 1'b0, '0, 1'b0);
        send_plain(OP_TURN_ON);
        send_plain(OP_ALERT);
        send_plain(OP_BROKER_UP);
        send_plain(OP_LINK_DOWN);
        send_plain(OP_LINK_UP);
        send_plain(OP_LINK_UP);
        send_item(OP_CURRENT_CHECK, 1'b0, '1, 1'b1);
        send_plain(OP_BROKER_UP);
        send_plain(OP_BROKER_LOST);
        send_plain(OP_BROKER_UP);
        send_plain(OP_TURN_OFF);
        send_item(OP_CURRENT_CHECK, 1'b0, '1, 1'b0);
        send_item(OP_CURRENT_CHECK, 1'b0, FAULT_RESET, 1'b1);
        send_item(OP_CURRENT_CHECK, 1'b0, FAULT_RESET + 1'b1, 1'b1);
        send_plain(OP_TURN_ON);
        send_plain(OP_ALERT_OFF);
        send_plain(OP_LINK_DOWN);
        send_plain(OP_LINK_UP);
        send_plain(OP_BROKER_UP);
        send_plain(OP_ALERT);
        send_plain(OP_ALERT_OFF);
        send_plain(OP_ALERT);
        send_plain(OP_TURN_OFF);
        send_item(OP_LAST_UNUSED, 1'b1, '1, 1'b1);
        send_item(OP_FIRST_UNUSED, 1'b0, '0, 1'b0);
        drain_results();

        // Lowest thresholds: any nonzero current faults and a press needs two ticks.
        set_thresholds(0, '0);
        run_phase(130, 31, 54);
        drain_results();

        // Highest thresholds: no current can fault and the debounce counter
        // has to run right up to saturation.
        set_thresholds(254, '1);
        run_phase(60, 54, 31);
        drain_results();

        set_thresholds($urandom_range(1, 8), 16'($urandom_range(50, 3000)));
        run_phase(130, 0, 0);

        // Runs of ticks after each pattern starts: long enough for the two
        // blinks to change slot, shorter looks at the long alternation and at
        // three blinks after an alert is switched off, and a press while
        // faulted.
        send_plain(OP_LINK_DOWN);
        send_plain(OP_LINK_UP);
        send_plain(OP_BROKER_UP);
        send_plain(OP_TURN_ON);
        repeat (int'(BLINK_MS) + 10) send_item(OP_TICK, 1'b0, '0, 1'b0);
        send_plain(OP_ALERT);
        repeat (20) send_item(OP_TICK, 1'b0, '0, 1'b0);
        send_plain(OP_TURN_OFF);
        repeat (20) send_item(OP_TICK, 1'b0, '0, 1'b0);
        press_button();
        drain_results();

        if (mismatches == 0 && results_pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/rpmc_pkg.sv
design/rpmc_step.sv
design/relay_plug_mode_controller_core.sv
tb/plug_mode_checker.sv
tb/tb_top.sv
